/* rtl/pcrg_pkg.sv */
// shared types, widths and helpers for the pinhole camera ray generator
// no dependencies; imported by every module of the block
package pcrg_pkg;

  // fixed-point and field widths
  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned MAX_SIDE   = 4096;
  localparam int unsigned SIDE_W     = 13;
  localparam int unsigned TAN_W      = 16;
  localparam int unsigned TY_W       = 29;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned ROW_W      = 48;
  localparam int unsigned POS_W      = 60;
  localparam int unsigned COORD_W    = 20;
  localparam int unsigned CFG_DATA_W = 60;
  localparam int unsigned CFG_IDX_W  = 3;

  // pipelined divider: quotient of at most FRAC_BITS + 1 bits
  localparam int unsigned DIV_NUM_W  = 44;
  localparam int unsigned DIV_DEN_W  = 29;
  localparam int unsigned DIV_QUO_W  = FRAC_BITS + 1;
  localparam int unsigned DIV_STAGES = DIV_QUO_W;

  // pipelined square root of the squared length
  localparam int unsigned LEN_W      = 58;
  localparam int unsigned ROOT_W     = LEN_W / 2;
  localparam int unsigned SQRT_STAGES = ROOT_W;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_TAN_HALF_HORZ = 3'd2,
    REG_ROT_ROW_X     = 3'd3,
    REG_ROT_ROW_Y     = 3'd4,
    REG_ROT_ROW_Z     = 3'd5,
    REG_CAM_POSITION  = 3'd6,
    REG_UNUSED        = 3'd7
  } cfg_reg_e;

  // sequencer for the vertical tangent division
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_DIV  = 3'b100
  } ty_state_e;

  typedef struct packed {
    logic [SIDE_W-1:0] pixel_x;
    logic [SIDE_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0]        direction_x;
    logic signed [15:0]        direction_y;
    logic signed [15:0]        direction_z;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
  } ray_t;

  // settled camera setup handed from the register block to the datapath
  typedef struct packed {
    logic              busy;
    logic [SIDE_W-1:0] side_w;
    logic [SIDE_W-1:0] side_h;
    logic [TAN_W-1:0]  tan_x;
    logic [TY_W-1:0]   tan_y;
    logic [ROW_W-1:0]  rot_x;
    logic [ROW_W-1:0]  rot_y;
    logic [ROW_W-1:0]  rot_z;
    logic [POS_W-1:0]  position;
  } cam_cfg_t;

  // zero side counts as one, oversized side as the maximum
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/pcrg_cfg.sv */
// configuration registers and the iterative vertical tangent divider
// depends on pcrg_pkg
module pcrg_cfg import pcrg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cam_cfg_t              cam_o
);

  logic [SIDE_W-1:0] width_q, height_q;
  logic [TAN_W-1:0]  tan_q;
  logic [ROW_W-1:0]  rot_x_q, rot_y_q, rot_z_q;
  logic [POS_W-1:0]  pos_q;
  ty_state_e         state_q, state_d;
  logic [TY_W-1:0]   num_q, num_d;
  logic [SIDE_W-1:0] rem_q, rem_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [SIDE_W-1:0] side_w, side_h;
  logic [SIDE_W:0]   trial;
  logic              ge;
  logic              restart;

  assign side_w = clamp_side(width_q);
  assign side_h = clamp_side(height_q);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIDE_W'(640);
      height_q <= SIDE_W'(480);
      tan_q    <= TAN_W'(12793);
      rot_x_q  <= ROW_W'(48'd16384);
      rot_y_q  <= ROW_W'(48'd16384) << 16;
      rot_z_q  <= ROW_W'(48'd16384) << 32;
      pos_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:   width_q  <= cfg_data_i[SIDE_W-1:0];
        REG_IMAGE_HEIGHT:  height_q <= cfg_data_i[SIDE_W-1:0];
        REG_TAN_HALF_HORZ: tan_q    <= cfg_data_i[TAN_W-1:0];
        REG_ROT_ROW_X:     rot_x_q  <= cfg_data_i[ROW_W-1:0];
        REG_ROT_ROW_Y:     rot_y_q  <= cfg_data_i[ROW_W-1:0];
        REG_ROT_ROW_Z:     rot_z_q  <= cfg_data_i[ROW_W-1:0];
        REG_CAM_POSITION:  pos_q    <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // any write to size or tangent redoes the vertical tangent
  assign restart = cfg_we_i && (cfg_idx_i == REG_IMAGE_WIDTH ||
                                cfg_idx_i == REG_IMAGE_HEIGHT ||
                                cfg_idx_i == REG_TAN_HALF_HORZ);

  // one quotient bit per cycle: ty = round(tx * h / w)
  assign trial = {rem_q, num_q[TY_W-1]};
  assign ge    = trial >= {1'b0, side_w};

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: ;
      ST_MUL: begin
        num_d   = TY_W'(tan_q * side_h) + TY_W'(side_w >> 1);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = ge ? SIDE_W'(trial - {1'b0, side_w}) : trial[SIDE_W-1:0];
        num_d = {num_q[TY_W-2:0], ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(TY_W - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_MUL;
    endcase
    if (restart) begin
      state_d = ST_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_MUL;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign cam_o.busy     = state_q != ST_IDLE;
  assign cam_o.side_w   = side_w;
  assign cam_o.side_h   = side_h;
  assign cam_o.tan_x    = tan_q;
  assign cam_o.tan_y    = num_q;
  assign cam_o.rot_x    = rot_x_q;
  assign cam_o.rot_y    = rot_y_q;
  assign cam_o.rot_z    = rot_z_q;
  assign cam_o.position = pos_q;

endmodule

/* rtl/pcrg_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on pcrg_pkg; quotient must fit DIV_QUO_W bits
module pcrg_div import pcrg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic [DIV_QUO_W-1:0] quo_o
);

  logic [DIV_NUM_W-1:0] rem_q [DIV_STAGES];
  logic [DIV_NUM_W-1:0] rem_d [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_q [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_d [DIV_STAGES];
  logic [DIV_QUO_W-1:0] quo_q [DIV_STAGES];
  logic [DIV_QUO_W-1:0] quo_d [DIV_STAGES];

  // each stage tries the shifted divisor for its own quotient bit
  always_comb begin
    logic [DIV_NUM_W-1:0] r;
    logic [DIV_NUM_W-1:0] t;
    logic [DIV_QUO_W-1:0] q;
    logic [DIV_DEN_W-1:0] d;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        r = num_i;
        d = den_i;
        q = '0;
      end else begin
        r = rem_q[k-1];
        d = den_q[k-1];
        q = quo_q[k-1];
      end
      t = DIV_NUM_W'(d) << (DIV_STAGES - 1 - k);
      if (r >= t) begin
        r = r - t;
        q[DIV_STAGES-1-k] = 1'b1;
      end
      rem_d[k] = r;
      den_d[k] = d;
      quo_d[k] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

/* rtl/pcrg_sqrt.sv */
// pipelined integer square root (floor), one root bit per stage
// depends on pcrg_pkg
module pcrg_sqrt import pcrg_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [LEN_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [LEN_W-1:0] x_q [SQRT_STAGES];
  logic [LEN_W-1:0] x_d [SQRT_STAGES];
  logic [LEN_W-1:0] r_q [SQRT_STAGES];
  logic [LEN_W-1:0] r_d [SQRT_STAGES];

  // digit-by-digit root with a fixed test bit per stage
  always_comb begin
    logic [LEN_W-1:0] x;
    logic [LEN_W-1:0] r;
    logic [LEN_W-1:0] b;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        x = rad_i;
        r = '0;
      end else begin
        x = x_q[k-1];
        r = r_q[k-1];
      end
      b = LEN_W'(1) << (2 * (SQRT_STAGES - 1 - k));
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      x_d[k] = x;
      r_d[k] = r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      r_q <= r_d;
    end
  end

  assign root_o = r_q[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

/* rtl/pinhole_camera_ray_generator_unit.sv */
// Pinhole camera ray generator: one pixel in, one primary ray out, one transaction
// per clock. Data passes through a fixed pipeline (two ranks of 15-stage dividers,
// a 29-stage square root, multipliers and rounding). The whole pipeline advances
// together and holds when a finished ray is stalled at the output. After reset and
// after any write to image_width, image_height or tan_half_horizontal, input is
// stalled while the vertical tangent is divided out bit by bit.
// Depends on pcrg_pkg, pcrg_cfg, pcrg_div and pcrg_sqrt.
module pinhole_camera_ray_generator_unit import pcrg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pixel_t                in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ray_t                  out_data_o
);

  localparam int unsigned DEPTH   = 68;
  localparam logic [DIV_NUM_W-1:0] ONE_SHIFTED = DIV_NUM_W'(1) << (2 * FRAC_BITS);

  cam_cfg_t cam;
  logic     en;
  logic     accept;
  logic     valid_q [DEPTH];

  pcrg_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cam_o     (cam)
  );

  // global advance: move when the output register is free or being taken
  assign en         = !valid_q[DEPTH-1] || !out_stall_i;
  assign in_stall_o = !en || cam.busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) valid_q[i] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= accept;
      for (int i = 1; i < DEPTH; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  // input register
  logic [SIDE_W-1:0] px_q, py_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= in_data_i.pixel_x;
      py_q <= in_data_i.pixel_y;
    end
  end

  // ndc numerators: |2q - side| * 2^F + side/2
  logic [SIDE_W-1:0]    qx, qy;
  logic [SIDE_W:0]      twox, twoy;
  logic [SIDE_W:0]      magx, magy;
  logic                 negx, negy;
  logic [DIV_NUM_W-1:0] ndc_num_x, ndc_num_y;
  always_comb begin
    qx   = (px_q > cam.side_w) ? cam.side_w : px_q;
    qy   = (py_q > cam.side_h) ? cam.side_h : py_q;
    twox = {qx, 1'b0};
    twoy = {qy, 1'b0};
    negx = twox < {1'b0, cam.side_w};
    negy = twoy < {1'b0, cam.side_h};
    magx = negx ? ({1'b0, cam.side_w} - twox) : (twox - {1'b0, cam.side_w});
    magy = negy ? ({1'b0, cam.side_h} - twoy) : (twoy - {1'b0, cam.side_h});
    ndc_num_x = (DIV_NUM_W'(magx) << FRAC_BITS) + DIV_NUM_W'(cam.side_w >> 1);
    ndc_num_y = (DIV_NUM_W'(magy) << FRAC_BITS) + DIV_NUM_W'(cam.side_h >> 1);
  end

  logic [DIV_QUO_W-1:0] ndc_x, ndc_y;
  pcrg_div u_div_ndc_x (
    .clk_i(clk_i), .en_i(en), .num_i(ndc_num_x),
    .den_i(DIV_DEN_W'(cam.side_w)), .quo_o(ndc_x)
  );
  pcrg_div u_div_ndc_y (
    .clk_i(clk_i), .en_i(en), .num_i(ndc_num_y),
    .den_i(DIV_DEN_W'(cam.side_h)), .quo_o(ndc_y)
  );

  // ndc sign follows the divider
  logic [1:0] ndc_neg_q [DIV_STAGES];
  always_ff @(posedge clk_i) begin
    if (en) begin
      ndc_neg_q[0] <= {negy, negx};
      for (int i = 1; i < DIV_STAGES; i++) ndc_neg_q[i] <= ndc_neg_q[i-1];
    end
  end

  // scale by tangents
  logic [30:0] prodx_q;
  logic [42:0] prody_q;
  logic [1:0]  neg_p_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      prodx_q <= 31'(ndc_x * cam.tan_x);
      prody_q <= 43'(ndc_y * cam.tan_y);
      neg_p_q <= ndc_neg_q[DIV_STAGES-1];
    end
  end

  // round to camera vector magnitudes
  logic [30:0] sum_vx;
  logic [43:0] sum_vy;
  logic [16:0] vxm_q;
  logic [28:0] vym_q;
  logic [1:0]  neg_v_q;
  assign sum_vx = prodx_q + 31'(1 << (FRAC_BITS - 1));
  assign sum_vy = {1'b0, prody_q} + 44'(1 << (FRAC_BITS - 1));
  always_ff @(posedge clk_i) begin
    if (en) begin
      vxm_q   <= sum_vx[30:14];
      vym_q   <= sum_vy[42:14];
      neg_v_q <= neg_p_q;
    end
  end

  // squares
  logic [33:0] sqx_q;
  logic [57:0] sqy_q;
  logic [16:0] vxm_s_q;
  logic [28:0] vym_s_q;
  logic [1:0]  neg_s_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q   <= vxm_q * vxm_q;
      sqy_q   <= vym_q * vym_q;
      vxm_s_q <= vxm_q;
      vym_s_q <= vym_q;
      neg_s_q <= neg_v_q;
    end
  end

  // squared length with the unit z term
  logic [LEN_W-1:0] len2_q;
  logic [16:0]      vxm_l_q;
  logic [28:0]      vym_l_q;
  logic [1:0]       neg_l_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      len2_q  <= LEN_W'(sqx_q) + sqy_q + LEN_W'(ONE_SHIFTED);
      vxm_l_q <= vxm_s_q;
      vym_l_q <= vym_s_q;
      neg_l_q <= neg_s_q;
    end
  end

  logic [ROOT_W-1:0] root;
  pcrg_sqrt u_sqrt (
    .clk_i(clk_i), .en_i(en), .rad_i(len2_q), .root_o(root)
  );

  // vector magnitudes ride along with the root
  logic [16:0] vxm_d_q [SQRT_STAGES];
  logic [28:0] vym_d_q [SQRT_STAGES];
  logic [1:0]  neg_d_q [SQRT_STAGES];
  always_ff @(posedge clk_i) begin
    if (en) begin
      vxm_d_q[0] <= vxm_l_q;
      vym_d_q[0] <= vym_l_q;
      neg_d_q[0] <= neg_l_q;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        vxm_d_q[i] <= vxm_d_q[i-1];
        vym_d_q[i] <= vym_d_q[i-1];
        neg_d_q[i] <= neg_d_q[i-1];
      end
    end
  end

  // normalization numerators: |v| * 2^F + s/2
  logic [DIV_NUM_W-1:0] nrm_num_x, nrm_num_y, nrm_num_z;
  logic [DIV_NUM_W-1:0] half_root;
  assign half_root = DIV_NUM_W'(root >> 1);
  assign nrm_num_x = (DIV_NUM_W'(vxm_d_q[SQRT_STAGES-1]) << FRAC_BITS) + half_root;
  assign nrm_num_y = (DIV_NUM_W'(vym_d_q[SQRT_STAGES-1]) << FRAC_BITS) + half_root;
  assign nrm_num_z = ONE_SHIFTED + half_root;

  logic [DIV_QUO_W-1:0] cxm, cym, czm;
  pcrg_div u_div_nrm_x (
    .clk_i(clk_i), .en_i(en), .num_i(nrm_num_x), .den_i(root), .quo_o(cxm)
  );
  pcrg_div u_div_nrm_y (
    .clk_i(clk_i), .en_i(en), .num_i(nrm_num_y), .den_i(root), .quo_o(cym)
  );
  pcrg_div u_div_nrm_z (
    .clk_i(clk_i), .en_i(en), .num_i(nrm_num_z), .den_i(root), .quo_o(czm)
  );

  logic [1:0] neg_c_q [DIV_STAGES];
  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_c_q[0] <= neg_d_q[SQRT_STAGES-1];
      for (int i = 1; i < DIV_STAGES; i++) neg_c_q[i] <= neg_c_q[i-1];
    end
  end

  // signed unit vector, saturated to one
  logic [DIV_QUO_W-1:0] one_q;
  logic [DIV_QUO_W-1:0] cxs, cys, czs;
  logic signed [15:0]   c_q [3];
  assign one_q = DIV_QUO_W'(1) << FRAC_BITS;
  assign cxs = (cxm > one_q) ? one_q : cxm;
  assign cys = (cym > one_q) ? one_q : cym;
  assign czs = (czm > one_q) ? one_q : czm;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q[0] <= neg_c_q[DIV_STAGES-1][0] ? -16'(signed'({1'b0, cxs})) : 16'({1'b0, cxs});
      c_q[1] <= neg_c_q[DIV_STAGES-1][1] ? -16'(signed'({1'b0, cys})) : 16'({1'b0, cys});
      c_q[2] <= -16'(signed'({1'b0, czs}));
    end
  end

  // rotation products
  logic [ROW_W-1:0]   rows [3];
  logic signed [31:0] p_q [3][3];
  assign rows[0] = cam.rot_x;
  assign rows[1] = cam.rot_y;
  assign rows[2] = cam.rot_z;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p_q[i][j] <= signed'(rows[i][COEF_W*j +: COEF_W]) * c_q[j];
        end
      end
    end
  end

  // dot product sums
  logic signed [33:0] acc_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= 34'(p_q[i][0]) + 34'(p_q[i][1]) + 34'(p_q[i][2]);
      end
    end
  end

  // round half away from zero, saturate, output register
  logic [33:0]        acc_mag [3];
  logic [33:0]        acc_rnd [3];
  logic [19:0]        dmag    [3];
  logic [15:0]        dsat    [3];
  logic signed [15:0] dir     [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_mag[i] = acc_q[i][33] ? 34'(-acc_q[i]) : 34'(acc_q[i]);
      acc_rnd[i] = acc_mag[i] + 34'(1 << (FRAC_BITS - 1));
      dmag[i]    = acc_rnd[i][33:14];
      dsat[i]    = (dmag[i] > 20'(1 << FRAC_BITS)) ? 16'(1 << FRAC_BITS) : dmag[i][15:0];
      dir[i]     = acc_q[i][33] ? -signed'(dsat[i]) : signed'(dsat[i]);
    end
  end

  ray_t out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.direction_x <= dir[0];
      out_q.direction_y <= dir[1];
      out_q.direction_z <= dir[2];
      out_q.origin_x    <= signed'(cam.position[COORD_W-1:0]);
      out_q.origin_y    <= signed'(cam.position[2*COORD_W-1:COORD_W]);
      out_q.origin_z    <= signed'(cam.position[3*COORD_W-1:2*COORD_W]);
    end
  end

  assign out_valid_o = valid_q[DEPTH-1];
  assign out_data_o  = out_q;

endmodule
